@@ rtl/core/stereo_state_variable_filter_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef STEREO_STATE_VARIABLE_FILTER_MACROS_SVH
`define STEREO_STATE_VARIABLE_FILTER_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define SSVF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ssvf assertion failed");

// Next-cycle implication, sampled at the rising clock edge, off during reset.
`define SSVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ssvf assertion failed");

`endif

@@ rtl/core/ssvf_pkg.sv @@
`timescale 1ns / 1ps

package ssvf_pkg;

  // Number formats.
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int STATE_BITS     = 32;
  localparam int MODE_BITS      = 3;

  // Product of an unsigned coefficient and a signed state value, and its
  // width after the fraction bits of the coefficient are dropped.
  localparam int PROD_BITS = COEF_BITS + 1 + STATE_BITS;
  localparam int PSH_BITS  = PROD_BITS - COEF_FRAC_BITS;
  // Accumulator holds the sum of up to three scaled products.
  localparam int ACC_BITS  = PSH_BITS + 2;

  // Configuration port.
  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 5;
  localparam int REG_IDX_BITS = ADDR_BITS - 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [PSH_BITS-1:0]    psh_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic        [COEF_BITS-1:0]   coef_t;
  typedef logic        [MODE_BITS-1:0]   mode_t;
  typedef logic        [REG_IDX_BITS-1:0] reg_idx_t;

  // Filter response codes.
  localparam mode_t MODE_LOWPASS  = MODE_BITS'(0);
  localparam mode_t MODE_HIGHPASS = MODE_BITS'(1);
  localparam mode_t MODE_BANDPASS = MODE_BITS'(2);
  localparam mode_t MODE_NOTCH    = MODE_BITS'(3);
  localparam mode_t MODE_PEAK     = MODE_BITS'(4);
  localparam mode_t MODE_ALLPASS  = MODE_BITS'(5);

  // Register indexes on the configuration port.
  localparam reg_idx_t REG_MODE = REG_IDX_BITS'(0);
  localparam reg_idx_t REG_A1   = REG_IDX_BITS'(1);
  localparam reg_idx_t REG_A2   = REG_IDX_BITS'(2);
  localparam reg_idx_t REG_A3   = REG_IDX_BITS'(3);
  localparam reg_idx_t REG_AK   = REG_IDX_BITS'(4);
  localparam reg_idx_t REG_K    = REG_IDX_BITS'(5);

  // Reset value of a1 is 1.0.
  localparam coef_t COEF_A1_RESET = COEF_BITS'(64'd1 << COEF_FRAC_BITS);

  // Saturation limits expressed in the accumulator width.
  localparam acc_t STATE_MAX_ACC =
    {{(ACC_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam acc_t STATE_MIN_ACC =
    {{(ACC_BITS-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
  localparam acc_t SAMPLE_MAX_ACC =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam acc_t SAMPLE_MIN_ACC =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  function automatic acc_t ext_sample(input sample_t x);
    return {{(ACC_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  endfunction

  function automatic acc_t ext_state(input state_t x);
    return {{(ACC_BITS-STATE_BITS){x[STATE_BITS-1]}}, x};
  endfunction

  function automatic acc_t ext_psh(input psh_t x);
    return {{(ACC_BITS-PSH_BITS){x[PSH_BITS-1]}}, x};
  endfunction

  // Clamp an accumulator value to the state width.
  function automatic state_t sat_state(input acc_t x);
    state_t r;
    if (x > STATE_MAX_ACC) begin
      r = {1'b0, {(STATE_BITS-1){1'b1}}};
    end else if (x < STATE_MIN_ACC) begin
      r = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      r = x[STATE_BITS-1:0];
    end
    return r;
  endfunction

  // Clamp an accumulator value to the sample width.
  function automatic sample_t sat_sample(input acc_t x);
    sample_t r;
    if (x > SAMPLE_MAX_ACC) begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (x < SAMPLE_MIN_ACC) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = x[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/stereo_state_variable_filter.sv @@
`timescale 1ns / 1ps

// Stereo state variable filter, trapezoidal integration, shared multiplier.
//
// Input channel: in_valid_i with left_in_i and right_in_i, stalled by in_stall_o.
// Output channel: out_valid_o with left_out_o and right_out_o, stalled by out_stall_i.
// An item moves at a clock edge with valid high and stall low. The APB port sets the mode
// and the coefficients, which the user must write only while idle; the block does not enforce this.
//
// One item runs nine sequencer steps per channel, left then right, on a single
// 25 x 32 bit multiplier with a registered product, used seven times per channel.
// A new item is taken only after both channels of the previous item have finished.
//
// A new item is taken while a finished result still waits on the output.
// If the receiver stalls, the sequencer holds in its final step until the
// output register frees up, so no result is lost or overwritten.
//
// Reset clears the integrators of both channels, loads the register reset
// values (lowpass, a1 = 1.0, all other coefficients zero) and empties the
// output register.
module stereo_state_variable_filter
  import ssvf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  // Output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam int STEP_BITS = 4;
  typedef logic [STEP_BITS-1:0] step_t;

  // Sequencer steps, named after the multiply issued in each.
  localparam step_t STEP_DIFF     = STEP_BITS'(0);
  localparam step_t STEP_MUL_A1V3 = STEP_BITS'(1);
  localparam step_t STEP_MUL_AKI1 = STEP_BITS'(2);
  localparam step_t STEP_MUL_A2V3 = STEP_BITS'(3);
  localparam step_t STEP_MUL_A1I1 = STEP_BITS'(4);
  localparam step_t STEP_MUL_A3V3 = STEP_BITS'(5);
  localparam step_t STEP_MUL_A2I1 = STEP_BITS'(6);
  localparam step_t STEP_MUL_KV1  = STEP_BITS'(7);
  localparam step_t STEP_OUT      = STEP_BITS'(8);

  // Configuration registers
  mode_t mode_q;
  coef_t a1_q, a2_q, a3_q, ak_q, k_q;

  // Sequencer
  state_e state_q, state_d;
  step_t  step_q;
  logic   ch_q;

  // Datapath
  sample_t x_q [2];
  state_t  ic1_q [2];
  state_t  ic2_q [2];
  state_t  v3_q, v0_q, v1_q, v2_q;
  acc_t    acc_q;
  psh_t    prod_q;
  sample_t left_res_q;
  sample_t left_out_q, right_out_q;
  logic    out_valid_q;

  logic    cfg_write;
  logic    in_accept;
  logic    out_free;
  logic    running;
  logic    last_step;
  logic    advance;
  logic    finish;
  coef_t   mul_coef;
  state_t  mul_val;
  logic signed [PROD_BITS-1:0] mul_full;
  acc_t    prod_e;
  acc_t    y_acc;
  sample_t y_sat;
  state_t  ic1_cur, ic2_cur;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LOWPASS;
      a1_q   <= COEF_A1_RESET;
      a2_q   <= '0;
      a3_q   <= '0;
      ak_q   <= '0;
      k_q    <= '0;
    end else if (cfg_write) begin
      case (paddr[ADDR_BITS-1:2])
        REG_MODE: mode_q <= pwdata[MODE_BITS-1:0];
        REG_A1:   a1_q   <= pwdata[COEF_BITS-1:0];
        REG_A2:   a2_q   <= pwdata[COEF_BITS-1:0];
        REG_A3:   a3_q   <= pwdata[COEF_BITS-1:0];
        REG_AK:   ak_q   <= pwdata[COEF_BITS-1:0];
        REG_K:    k_q    <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (paddr[ADDR_BITS-1:2])
      REG_MODE: prdata = DATA_BITS'(mode_q);
      REG_A1:   prdata = DATA_BITS'(a1_q);
      REG_A2:   prdata = DATA_BITS'(a2_q);
      REG_A3:   prdata = DATA_BITS'(a3_q);
      REG_AK:   prdata = DATA_BITS'(ak_q);
      REG_K:    prdata = DATA_BITS'(k_q);
      default:  prdata = '0;
    endcase
  end

  // Handshake and sequencer control.
  assign running     = (state_q == ST_RUN);
  assign in_stall_o  = !(state_q == ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_step   = (step_q == STEP_OUT);
  assign advance     = running && (!last_step || !ch_q || out_free);
  assign finish      = running && last_step && ch_q && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_RUN;
      ST_RUN:  if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_DIFF;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        step_q <= STEP_DIFF;
        ch_q   <= 1'b0;
      end else if (advance) begin
        if (last_step) begin
          step_q <= STEP_DIFF;
          ch_q   <= 1'b1;
        end else begin
          step_q <= step_q + STEP_BITS'(1);
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand selection for the shared multiplier.
  assign ic1_cur = ic1_q[ch_q];
  assign ic2_cur = ic2_q[ch_q];

  always_comb begin
    mul_coef = a1_q;
    mul_val  = v3_q;
    case (step_q)
      STEP_MUL_A1V3: begin mul_coef = a1_q; mul_val = v3_q;    end
      STEP_MUL_AKI1: begin mul_coef = ak_q; mul_val = ic1_cur; end
      STEP_MUL_A2V3: begin mul_coef = a2_q; mul_val = v3_q;    end
      STEP_MUL_A1I1: begin mul_coef = a1_q; mul_val = ic1_cur; end
      STEP_MUL_A3V3: begin mul_coef = a3_q; mul_val = v3_q;    end
      STEP_MUL_A2I1: begin mul_coef = a2_q; mul_val = ic1_cur; end
      STEP_MUL_KV1:  begin mul_coef = k_q;  mul_val = v1_q;    end
      default:       begin mul_coef = a1_q; mul_val = v3_q;    end
    endcase
  end

  // Signed product; dropping the coefficient fraction bits floors it.
  assign mul_full = $signed({1'b0, mul_coef}) * mul_val;
  assign prod_e   = ext_psh(prod_q);

  // Response selection from the node values of the current channel.
  always_comb begin
    case (mode_q)
      MODE_LOWPASS:  y_acc = ext_state(v2_q);
      MODE_HIGHPASS: y_acc = ext_state(v0_q);
      MODE_BANDPASS: y_acc = ext_state(v1_q);
      MODE_NOTCH:    y_acc = ext_state(v2_q) + ext_state(v0_q);
      MODE_PEAK:     y_acc = ext_state(v2_q) - ext_state(v0_q);
      MODE_ALLPASS:  y_acc = ext_state(v2_q) + ext_state(v0_q) - prod_e;
      default:       y_acc = '0;
    endcase
  end

  assign y_sat = sat_sample(y_acc);

  // Input capture and the arithmetic steps of one channel.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q[0] <= left_in_i;
      x_q[1] <= right_in_i;
    end
    if (running) begin
      // The product holds while the final step waits for the output.
      if (advance) begin
        prod_q <= mul_full[PROD_BITS-1:COEF_FRAC_BITS];
      end
      case (step_q)
        STEP_DIFF:     v3_q  <= sat_state(ext_sample(x_q[ch_q]) - ext_state(ic2_cur));
        STEP_MUL_AKI1: acc_q <= prod_e;
        STEP_MUL_A2V3: v0_q  <= sat_state(acc_q - prod_e);
        STEP_MUL_A1I1: acc_q <= prod_e;
        STEP_MUL_A3V3: v1_q  <= sat_state(acc_q + prod_e);
        STEP_MUL_A2I1: acc_q <= prod_e + ext_state(ic2_cur);
        STEP_MUL_KV1:  v2_q  <= sat_state(acc_q + prod_e);
        STEP_OUT:      if (!ch_q) left_res_q <= y_sat;
        default: ;
      endcase
    end
    if (finish) begin
      left_out_q  <= left_res_q;
      right_out_q <= y_sat;
    end
  end

  // Trapezoidal integrator updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        ic1_q[i] <= '0;
        ic2_q[i] <= '0;
      end
    end else if (running) begin
      if (step_q == STEP_MUL_A2I1) begin
        ic1_q[ch_q] <= sat_state((ext_state(v1_q) <<< 1) - ext_state(ic1_cur));
      end
      if (last_step && advance) begin
        ic2_q[ch_q] <= sat_state((ext_state(v2_q) <<< 1) - ext_state(ic2_cur));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

@@ rtl/core/ssvf_checker.sv @@
`timescale 1ns / 1ps

`include "stereo_state_variable_filter_macros.svh"

module ssvf_checker
  import ssvf_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_o,
  input logic signed [SAMPLE_BITS-1:0] right_out_o
);

  logic in_take;
  logic out_hold;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  // A taken item keeps the block busy in the following cycle.
  `SSVF_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_take, in_stall_o)

  // A result appears only at the end of work, never straight after a take.
  `SSVF_ASSERT_SAME(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  `SSVF_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_take, !$rose(out_valid_o))

  // A stalled result holds its samples.
  `SSVF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(left_out_o) && $stable(right_out_o))

endmodule

bind stereo_state_variable_filter ssvf_checker u_ssvf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .left_out_o  (left_out_o),
  .right_out_o (right_out_o)
);
